[rtl/sparse_table_range_min_max_assert.svh]
// Assertion macros for the sparse table range min/max block.
`ifndef SPARSE_TABLE_RANGE_MIN_MAX_ASSERT_SVH
`define SPARSE_TABLE_RANGE_MIN_MAX_ASSERT_SVH
`ifndef SYNTHESIS
`define STRMM_ASSERT_NOW(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define STRMM_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define STRMM_ASSERT_NOW(name, clk, rst, pre, post)
`define STRMM_ASSERT_NEXT(name, clk, rst, pre, post)
`endif
`endif

[rtl/strmm_pkg.sv]
// Shared constants, types and helper functions of the sparse table block.
package strmm_pkg;

   localparam int MAX_ELEMENTS = 1024;
   localparam int LEVELS       = 11;
   localparam int DATA_W       = 64;
   localparam int IDX_W        = 11;
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
   localparam int POS_W        = $clog2(MAX_ELEMENTS);
   localparam int LVL_W        = $clog2(LEVELS);
   localparam int TBL_DEPTH    = LEVELS * MAX_ELEMENTS;
   localparam int TBL_AW       = $clog2(TBL_DEPTH);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

   // Command codes on the request channel.
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_BUILD = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_COUNT = 1'b0;
   localparam logic CSR_MODE  = 1'b1;

   // Queued operation kinds.
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_BUILD = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   typedef struct packed {
      logic [1:0]               op;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
      logic                     bad;
      logic [LVL_W-1:0]         lvl;
      logic [POS_W-1:0]         pos_a;
      logic [POS_W-1:0]         pos_b;
   } qentry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // Floor of log2, capped at the top level.
   function automatic logic [LVL_W-1:0] floor_log2(input logic [CNT_W-1:0] v);
      logic [LVL_W-1:0] k;
      k = '0;
      for (int i = 1; i < CNT_W; i++) begin
         if (v[i]) begin
            k = LVL_W'(i);
         end
      end
      if (k > LVL_W'(LEVELS - 1)) begin
         k = LVL_W'(LEVELS - 1);
      end
      return k;
   endfunction

   // Keeps the minimum (mode 0) or the maximum (mode 1) of two signed words.
   function automatic logic signed [DATA_W-1:0] pick(input logic signed [DATA_W-1:0] a,
                                                     input logic signed [DATA_W-1:0] b,
                                                     input logic mode);
      logic a_less;
      a_less = (a < b);
      if (mode) begin
         return a_less ? b : a;
      end
      return a_less ? a : b;
   endfunction

   // Table address of a position on a level.
   function automatic logic [TBL_AW-1:0] tbl_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [POS_W-1:0] pos);
      return TBL_AW'(lvl) * TBL_AW'(MAX_ELEMENTS) + TBL_AW'(pos);
   endfunction

endpackage

[rtl/strmm_queue.sv]
// Small queue between the classifying front end and the executing back end.
module strmm_queue
   import strmm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  qentry_type push_entry,
   input  logic       pop,
   output qentry_type head_entry,
   output qstat_type  stat
);

   qentry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    fill_ff, fill_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      fill_in   = fill_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry = slot_ff[rd_ptr_ff];
   assign stat.full  = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign stat.empty = (fill_ff == '0);

endmodule

[rtl/strmm_front.sv]
// Front end: accepts request transactions and classifies them for the queue.
module strmm_front
   import strmm_pkg::*;
(
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_cmd,
   input  logic [IDX_W-1:0]         req_element_index,
   input  logic signed [DATA_W-1:0] req_element_value,
   input  logic [IDX_W-1:0]         req_query_left,
   input  logic [IDX_W-1:0]         req_query_right,
   input  logic [CNT_W-1:0]         eff_count,
   input  qstat_type                qstat,
   output logic                     push,
   output qentry_type               push_entry
);

   logic             keep;
   logic [IDX_W-1:0] range_len;
   logic [LVL_W-1:0] k;

   assign req_ready = !qstat.full;

   // Decide whether the transaction has any effect, and precompute query windows.
   always_comb begin
      range_len = req_query_right - req_query_left + IDX_W'(1);
      k         = floor_log2(CNT_W'(range_len));
      case (req_cmd)
         CMD_LOAD:  keep = (req_element_index != '0) &&
                           (req_element_index <= IDX_W'(MAX_ELEMENTS));
         CMD_BUILD: keep = 1'b1;
         CMD_QUERY: keep = 1'b1;
         default:   keep = 1'b0;
      endcase
      push_entry.op    = (req_cmd == CMD_LOAD) ? OP_LOAD :
                         (req_cmd == CMD_BUILD) ? OP_BUILD : OP_QUERY;
      push_entry.pos   = POS_W'(req_element_index - IDX_W'(1));
      push_entry.value = req_element_value;
      push_entry.bad   = (req_query_left == '0) ||
                         (req_query_left > req_query_right) ||
                         (CNT_W'(req_query_right) > eff_count);
      push_entry.lvl   = k;
      push_entry.pos_a = POS_W'(req_query_left - IDX_W'(1));
      push_entry.pos_b = POS_W'(req_query_right - (IDX_W'(1) << k));
   end

   assign push = req_valid && req_ready && keep;

endmodule

[rtl/strmm_back.sv]
// Back end: executes loads, builds and queries against the level table.
module strmm_back
   import strmm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  qentry_type               head_entry,
   input  qstat_type                qstat,
   output logic                     pop,
   input  logic [CNT_W-1:0]         eff_count,
   input  logic                     compare_mode,
   input  logic                     csr_touch,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_range_result,
   output logic                     rsp_range_error
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_QREAD = 2'd1;
   localparam logic [1:0] ST_BREAD = 2'd2;
   localparam logic [1:0] ST_BWRITE = 2'd3;

   logic signed [DATA_W-1:0] table_mem [TBL_DEPTH];
   logic signed [DATA_W-1:0] rd_a_ff, rd_b_ff;

   logic [1:0]               state_ff, state_in;
   logic                     built_ff, built_in;
   logic [LVL_W-1:0]         lvl_ff, lvl_in;
   logic [LVL_W-1:0]         top_ff, top_in;
   logic [CNT_W-1:0]         j_ff, j_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] result_ff, result_in;
   logic                     error_ff, error_in;

   logic                     we;
   logic [TBL_AW-1:0]        wa, ra, rb;
   logic signed [DATA_W-1:0] wd;
   logic                     out_free;
   logic [CNT_W:0]           span_end;
   logic [POS_W-1:0]         half_pos;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign span_end = (CNT_W+1)'(j_ff) + ((CNT_W+1)'(1) << lvl_ff);
   assign half_pos = POS_W'(j_ff) + (POS_W'(1) << (lvl_ff - LVL_W'(1)));

   // Sequencer for one queued operation at a time.
   always_comb begin
      state_in     = state_ff;
      built_in     = built_ff;
      lvl_in       = lvl_ff;
      top_in       = top_ff;
      j_in         = j_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      result_in    = result_ff;
      error_in     = error_ff;
      pop          = 1'b0;
      we           = 1'b0;
      wa           = tbl_addr(lvl_ff, POS_W'(j_ff));
      wd           = pick(rd_a_ff, rd_b_ff, compare_mode);
      ra           = tbl_addr(head_entry.lvl, head_entry.pos_a);
      rb           = tbl_addr(head_entry.lvl, head_entry.pos_b);
      case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty && (head_entry.op != OP_QUERY || out_free)) begin
               pop = 1'b1;
               case (head_entry.op)
                  OP_LOAD: begin
                     we       = 1'b1;
                     wa       = tbl_addr('0, head_entry.pos);
                     wd       = head_entry.value;
                     built_in = 1'b0;
                  end
                  OP_BUILD: begin
                     lvl_in = LVL_W'(1);
                     j_in   = '0;
                     top_in = floor_log2(eff_count);
                     if (eff_count < CNT_W'(2)) begin
                        built_in = 1'b1;
                     end else begin
                        state_in = ST_BREAD;
                     end
                  end
                  default: begin
                     if (!built_ff || head_entry.bad) begin
                        rsp_valid_in = 1'b1;
                        result_in    = '0;
                        error_in     = 1'b1;
                     end else begin
                        state_in = ST_QREAD;
                     end
                  end
               endcase
            end
         end
         ST_QREAD: begin
            rsp_valid_in = 1'b1;
            result_in    = pick(rd_a_ff, rd_b_ff, compare_mode);
            error_in     = 1'b0;
            state_in     = ST_IDLE;
         end
         ST_BREAD: begin
            ra = tbl_addr(lvl_ff - LVL_W'(1), POS_W'(j_ff));
            rb = tbl_addr(lvl_ff - LVL_W'(1), half_pos);
            if (span_end <= (CNT_W+1)'(eff_count)) begin
               state_in = ST_BWRITE;
            end else if (lvl_ff == top_ff) begin
               built_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               lvl_in = lvl_ff + LVL_W'(1);
               j_in   = '0;
            end
         end
         default: begin
            we       = 1'b1;
            j_in     = j_ff + CNT_W'(1);
            state_in = ST_BREAD;
         end
      endcase
      if (csr_touch) begin
         built_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         built_ff     <= built_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Counters and result payload.
   always_ff @(posedge clock) begin
      lvl_ff    <= lvl_in;
      top_ff    <= top_in;
      j_ff      <= j_in;
      result_ff <= result_in;
      error_ff  <= error_in;
   end

   // Level table: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (we) begin
         table_mem[wa] <= wd;
      end
      rd_a_ff <= table_mem[ra];
      rd_b_ff <= table_mem[rb];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_range_result = result_ff;
   assign rsp_range_error  = error_ff;

endmodule

[rtl/sparse_table_range_min_max.sv]
// Top level of the sparse table range minimum/maximum block.
//
// Request channel (req_): cmd 0 loads element_value at 1-based element_index,
// cmd 1 builds every level of the table, cmd 2 asks for the min or max over
// [query_left, query_right]. Response channel (rsp_): one transaction per
// query with range_result and range_error; loads and builds answer nothing.
// Configuration (csr_): element_count (index 0) and compare_mode (index 1);
// the user must write them only while the block is idle, which the block
// itself does not enforce; any write invalidates the table. Requests enter a
// four-entry queue, so up to four are taken while the back end is busy. A
// query's table read is registered; a build alternates reads of the level
// below with writes through the single write port of the table memory.
// After reset the table counts as unbuilt and every query reports an error.
// A stalled receiver holds the response register; the back end then stops at
// the next query while loads and builds ahead of it still proceed.
`include "sparse_table_range_min_max_assert.svh"
module sparse_table_range_min_max
   import strmm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_cmd,
   input  logic [IDX_W-1:0]         req_element_index,
   input  logic signed [DATA_W-1:0] req_element_value,
   input  logic [IDX_W-1:0]         req_query_left,
   input  logic [IDX_W-1:0]         req_query_right,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_range_result,
   output logic                     rsp_range_error,
   input  logic                     csr_we,
   input  logic                     csr_addr,
   input  logic [CNT_W-1:0]         csr_wdata
);

   logic [CNT_W-1:0] count_ff;
   logic             mode_ff;
   logic [CNT_W-1:0] eff_count;
   logic             push, pop;
   qentry_type       push_entry, head_entry;
   qstat_type        qstat;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(1);
         mode_ff  <= 1'b0;
      end else if (csr_we) begin
         if (csr_addr == CSR_COUNT) begin
            count_ff <= csr_wdata;
         end else begin
            mode_ff <= csr_wdata[0];
         end
      end
   end

   assign eff_count = (count_ff > CNT_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS) : count_ff;

   strmm_front u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .req_query_left    (req_query_left),
      .req_query_right   (req_query_right),
      .eff_count         (eff_count),
      .qstat             (qstat),
      .push              (push),
      .push_entry        (push_entry)
   );

   strmm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .stat       (qstat)
   );

   strmm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_entry       (head_entry),
      .qstat            (qstat),
      .pop              (pop),
      .eff_count        (eff_count),
      .compare_mode     (mode_ff),
      .csr_touch        (csr_we),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_range_result (rsp_range_result),
      .rsp_range_error  (rsp_range_error)
   );

   // The queue is never written when full nor read when empty.
   `STRMM_ASSERT_NOW(a_no_overflow, clock, reset, push, !qstat.full)
   `STRMM_ASSERT_NOW(a_no_underflow, clock, reset, pop, !qstat.empty)
   // A rejected query always carries a zero value.
   `STRMM_ASSERT_NOW(a_error_zero, clock, reset, rsp_valid && rsp_range_error, rsp_range_result == '0)
   // A response stays up until the transaction completes.
   `STRMM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

endmodule

[verif/sparse_table_range_checker.sv]
// Checker for the sparse table block: predicts range answers and compares responses.
module sparse_table_range_checker
   import strmm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [1:0]               req_cmd,
   input  logic [IDX_W-1:0]         req_element_index,
   input  logic signed [DATA_W-1:0] req_element_value,
   input  logic [IDX_W-1:0]         req_query_left,
   input  logic [IDX_W-1:0]         req_query_right,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic signed [DATA_W-1:0] rsp_range_result,
   input  logic                     rsp_range_error,
   input  logic                     csr_we,
   input  logic                     csr_addr,
   input  logic [CNT_W-1:0]         csr_wdata,
   output int                       fail_count,
   output int                       answers_pending,
   output int                       answers_seen,
   output int                       error_answers
);

   typedef struct {
      logic [DATA_W-1:0] value;
      logic              err;
   } range_answer_type;

   // Private copy of the table and its settings.
   logic [DATA_W-1:0] sparse_lvl [LEVELS][MAX_ELEMENTS];
   logic              table_ready;
   int                elem_count;
   logic              keep_max;
   range_answer_type  answer_q[$];

   // Floor of log2, capped at the top level of the table.
   function automatic int span_level(input int v);
      int k;
      k = 0;
      while (v > 1) begin
         v = v >> 1;
         k++;
      end
      if (k > LEVELS - 1) begin
         k = LEVELS - 1;
      end
      return k;
   endfunction

   // Keeps the smaller or the larger of two signed words, per the mode.
   function automatic logic [DATA_W-1:0] keep_one(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
      logic a_below;
      a_below = ($signed(a) < $signed(b));
      if (keep_max) begin
         return a_below ? b : a;
      end
      return a_below ? a : b;
   endfunction

   function automatic int used_count();
      return (elem_count > MAX_ELEMENTS) ? MAX_ELEMENTS : elem_count;
   endfunction

   // Fills every level above level 0 from the level below it.
   task automatic rebuild_levels();
      int n;
      int top;
      n = used_count();
      if (n > 0) begin
         top = span_level(n);
         for (int lvl = 1; lvl <= top; lvl++) begin
            for (int j = 0; j + (1 << lvl) <= n; j++) begin
               sparse_lvl[lvl][j] = keep_one(sparse_lvl[lvl-1][j],
                                             sparse_lvl[lvl-1][j + (1 << (lvl-1))]);
            end
         end
      end
      table_ready = 1'b1;
   endtask

   // Works out the answer to one query transaction.
   function automatic range_answer_type answer_range(input int lft, input int rgt);
      range_answer_type ans;
      int k;
      if (!table_ready || lft == 0 || lft > rgt || rgt > used_count()) begin
         ans.value = '0;
         ans.err   = 1'b1;
      end else begin
         k = span_level(rgt - lft + 1);
         ans.value = keep_one(sparse_lvl[k][lft-1], sparse_lvl[k][rgt - (1 << k)]);
         ans.err   = 1'b0;
      end
      return ans;
   endfunction

   always @(posedge clock) begin
      range_answer_type want;
      if (reset) begin
         table_ready     = 1'b0;
         elem_count      = 1;
         keep_max        = 1'b0;
         answer_q        = {};
         fail_count      = 0;
         answers_seen    = 0;
         error_answers   = 0;
         answers_pending = 0;
      end else begin
         // Compare a response transaction with the oldest expectation.
         if (rsp_valid && rsp_ready) begin
            answers_seen++;
            if (rsp_range_error) begin
               error_answers++;
            end
            if (answer_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("unexpected response: result %0d error %0b",
                           rsp_range_result, rsp_range_error);
               end
            end else begin
               want = answer_q.pop_front();
               if (rsp_range_result !== want.value || rsp_range_error !== want.err) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch: expected result %0d error %0b, got %0d error %0b",
                              $signed(want.value), want.err, rsp_range_result,
                              rsp_range_error);
                  end
               end
            end
         end
         // Track register writes; any write makes the table stale.
         if (csr_we) begin
            if (csr_addr == CSR_COUNT) begin
               elem_count = int'(csr_wdata);
            end else begin
               keep_max = csr_wdata[0];
            end
            table_ready = 1'b0;
         end
         // Apply an accepted request transaction.
         if (req_valid && req_ready) begin
            case (req_cmd)
               CMD_LOAD: begin
                  if (req_element_index >= 1 && req_element_index <= MAX_ELEMENTS) begin
                     sparse_lvl[0][req_element_index - 1] = req_element_value;
                     table_ready = 1'b0;
                  end
               end
               CMD_BUILD: begin
                  rebuild_levels();
               end
               CMD_QUERY: begin
                  answer_q.push_back(answer_range(req_query_left, req_query_right));
               end
               default: begin
               end
            endcase
         end
         answers_pending = answer_q.size();
      end
   end

endmodule

[verif/testbench.sv]
// Top of the sparse table testbench: clock, reset, stimulus and verdict.
module testbench;
   import strmm_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [DATA_W-1:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [DATA_W-1:0] VAL_MIN = 64'h8000_0000_0000_0000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [1:0]               req_cmd;
   logic [IDX_W-1:0]         req_element_index;
   logic signed [DATA_W-1:0] req_element_value;
   logic [IDX_W-1:0]         req_query_left;
   logic [IDX_W-1:0]         req_query_right;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [DATA_W-1:0] rsp_range_result;
   logic                     rsp_range_error;
   logic                     csr_we;
   logic                     csr_addr;
   logic [CNT_W-1:0]         csr_wdata;
   int                       fail_count;
   int                       answers_pending;
   int                       answers_seen;
   int                       error_answers;

   logic calm;
   int   stall_left;
   int   cur_count;
   int   item_total;
   int   random_items;
   int   phase_total;

   sparse_table_range_min_max dut (.*);

   sparse_table_range_checker checker_i (.*);

   initial begin
      clock = 1'b0;
   end
   always #5 clock = ~clock;

   // Receiver side: random stall bursts unless the run is in its calm tail.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ready = 1'b1;
         if (!calm && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 19);
         end
      end
   end

   // Offers one request transaction and waits for it to be taken.
   task automatic send_req(input logic [1:0] cmd, input int idx,
                           input logic [DATA_W-1:0] val, input int lft, input int rgt);
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_valid         = 1'b1;
      req_cmd           = cmd;
      req_element_index = IDX_W'(idx);
      req_element_value = val;
      req_query_left    = IDX_W'(lft);
      req_query_right   = IDX_W'(rgt);
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      item_total++;
   endtask

   task automatic load_elem(input int idx, input logic [DATA_W-1:0] val);
      send_req(CMD_LOAD, idx, val, $urandom_range(0, 2047), $urandom_range(0, 2047));
   endtask

   task automatic ask_range(input int lft, input int rgt);
      send_req(CMD_QUERY, $urandom_range(0, 2047), {$urandom, $urandom}, lft, rgt);
   endtask

   task automatic build_table();
      send_req(CMD_BUILD, $urandom_range(0, 2047), {$urandom, $urandom},
               $urandom_range(0, 2047), $urandom_range(0, 2047));
   endtask

   // Holds off until every answer is in and a pending build has surely finished.
   task automatic drain();
      int n;
      req_valid = 1'b0;
      while (answers_pending != 0) @(negedge clock);
      n = (cur_count > MAX_ELEMENTS) ? MAX_ELEMENTS : cur_count;
      repeat (2 * LEVELS * n + 64) @(negedge clock);
   endtask

   task automatic write_reg(input logic addr, input int data);
      csr_we    = 1'b1;
      csr_addr  = addr;
      csr_wdata = CNT_W'(data);
      if (addr == CSR_COUNT) begin
         cur_count = data;
      end
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // New setting: drain, then write both registers in random order.
   task automatic start_phase(input int count, input logic mode);
      drain();
      if ($urandom_range(0, 1)) begin
         write_reg(CSR_COUNT, count);
         write_reg(CSR_MODE, mode);
      end else begin
         write_reg(CSR_MODE, mode);
         write_reg(CSR_COUNT, count);
      end
      phase_total++;
   endtask

   function automatic logic [DATA_W-1:0] any_value();
      case ($urandom_range(0, 5))
         0: return VAL_MAX;
         1: return VAL_MIN;
         2, 3: return DATA_W'($signed($urandom_range(0, 6)) - 3);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic fill_elems(input int count);
      int n;
      n = (count > MAX_ELEMENTS) ? MAX_ELEMENTS : count;
      for (int i = 1; i <= n; i++) begin
         load_elem(i, any_value());
         random_items++;
      end
   endtask

   initial begin
      int   n;
      int   lft;
      int   rgt;
      int   ops;
      logic [DATA_W-1:0] edge_vals [8];

      reset = 1'b1;
      calm = 1'b0;
      stall_left = 0;
      rsp_ready = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_LOAD;
      req_element_index = '0;
      req_element_value = '0;
      req_query_left = '0;
      req_query_right = '0;
      csr_we = 1'b0;
      csr_addr = CSR_COUNT;
      csr_wdata = '0;
      cur_count = 1;
      item_total = 0;
      random_items = 0;
      phase_total = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset setting: query before any build, ignored loads, unknown command.
      ask_range(1, 1);
      load_elem(0, VAL_MAX);
      load_elem(1025, VAL_MAX);
      load_elem(2047, VAL_MIN);
      send_req(CMD_UNUSED, 2047, '1, 2047, 2047);
      load_elem(1, VAL_MIN);
      ask_range(1, 1);

      // Eight elements in max mode with the extreme values, then bad ranges.
      start_phase(8, 1'b1);
      edge_vals = '{VAL_MAX, VAL_MIN, 0, '1, 1, 5, VAL_MAX, VAL_MIN};
      for (int i = 0; i < 8; i++) begin
         load_elem(i + 1, edge_vals[i]);
      end
      build_table();
      ask_range(1, 8);
      ask_range(1, 1);
      ask_range(8, 8);
      ask_range(3, 6);
      ask_range(0, 2);
      ask_range(5, 4);
      ask_range(1, 9);
      ask_range(2047, 2047);
      // Let the sender wait until every answer has come back.
      drain();
      load_elem(2, 7);
      ask_range(1, 2);

      // An empty table: build fills nothing and every query is rejected.
      start_phase(0, 1'b0);
      build_table();
      ask_range(1, 1);

      // Count beyond the table size acts as a full table.
      start_phase(2047, 1'b0);
      fill_elems(2047);
      build_table();
      ask_range(1, 1024);
      ask_range(1, 1023);
      ask_range(512, 1024);
      ask_range(1, 1025);

      // Random phases: mostly well-formed queries over small tables.
      while (random_items < 1450) begin
         if (random_items > 1250) begin
            calm = 1'b1;
         end
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 48);
         start_phase(n, $urandom_range(0, 1));
         fill_elems(n);
         build_table();
         random_items++;
         ops = $urandom_range(20, 60);
         for (int i = 0; i < ops; i++) begin
            case ($urandom_range(0, 19))
               0: begin
                  ask_range($urandom_range(0, 2047), $urandom_range(0, 2047));
               end
               1: begin
                  // A reload leaves the table stale until the next build.
                  load_elem($urandom_range(1, n), any_value());
                  ask_range(1, n);
                  if ($urandom_range(0, 1)) begin
                     build_table();
                  end
               end
               2: begin
                  send_req(CMD_UNUSED, $urandom_range(0, 2047), {$urandom, $urandom},
                           $urandom_range(0, 2047), $urandom_range(0, 2047));
               end
               3: begin
                  load_elem($urandom_range(0, 1) ? 0 : $urandom_range(1025, 2047),
                            {$urandom, $urandom});
               end
               default: begin
                  lft = $urandom_range(1, n);
                  rgt = $urandom_range(lft, n);
                  ask_range(lft, rgt);
               end
            endcase
            random_items++;
         end
      end

      // Wind down: everything answered, then room for the last pipeline stages.
      calm = 1'b1;
      req_valid = 1'b0;
      while (answers_pending != 0) @(negedge clock);
      repeat (50) @(posedge clock);
      $display("Sent %0d request transactions over %0d register settings.",
               item_total, phase_total);
      $display("Checked %0d range answers, %0d of them rejected ranges.",
               answers_seen, error_answers);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #20000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
